/* sv/pcm_pkg.sv */
// ----------------------------------------------------------------------------
// pcm_pkg: shared types and constants for the pseudocolor map
// Sample format, channel width, internal datapath widths and map codes.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 12;
    localparam int CHANNEL_BITS = 8;

    localparam int CMAX = (1 << CHANNEL_BITS) - 1;

    // sample-unit quantities are carried at ten times their value
    localparam int SW = SAMPLE_BITS + 4;        // signed 10x sample
    localparam int DW = SW;                     // unsigned offset and width
    localparam int CW = DW + 7;                 // segment compares (100x)
    localparam int NW = SW + 14;                // signed numerator, den = 400 * width
    localparam int YW = DW + 10;                // divisor, 800 * width
    localparam int RW = NW + CHANNEL_BITS + 2;  // dividend

    localparam int DIV_STAGES = CHANNEL_BITS;

    // jet offsets 0.2 and 0.8 at ten times sample units
    localparam int O2 = 2 << FRAC_BITS;
    localparam int O8 = 8 << FRAC_BITS;

    // fixed jet range -0.1 .. 0.3 at ten times sample units
    localparam logic signed [SW-1:0] FIXED_LO = SW'(-(1 << FRAC_BITS));
    localparam logic signed [SW-1:0] FIXED_HI = SW'(3 << FRAC_BITS);

    localparam logic [1:0] REG_MAP_SELECT = 2'd0;
    localparam logic [1:0] REG_RANGE_MIN  = 2'd1;
    localparam logic [1:0] REG_RANGE_MAX  = 2'd2;

    typedef enum logic [2:0] {
        MAP_JET,
        MAP_HOT_TO_COLD,
        MAP_COOL,
        MAP_WINTER,
        MAP_HOT,
        MAP_SUMMER,
        MAP_JET_FIXED
    } map_sel_t;

    typedef logic [2:0] seg_t;

    function automatic logic signed [SW-1:0] times10(input logic signed [SAMPLE_BITS-1:0] x);
        logic signed [SW-1:0] w;
        w = SW'(x);
        return (w <<< 3) + (w <<< 1);
    endfunction

endpackage

/* sv/pseudocolor_map.sv */
// ----------------------------------------------------------------------------
// pseudocolor_map: false-color stage, signed sample to RGB levels
// Clamp, segment select, per-channel numerators, then a pipelined divider.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one color per sample, in order.
// Five stages (input, clamp, segment decode, numerators, dividend setup)
// feed a restoring divider that resolves one bit of each channel level
// per stage. A stall on the output holds the whole pipeline; cfg_ready is
// always high and registers may be written only while no item is in flight.
module pseudocolor_map import pcm_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  sample_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [CHANNEL_BITS-1:0]        red_level,
    output logic [CHANNEL_BITS-1:0]        green_level,
    output logic [CHANNEL_BITS-1:0]        blue_level,
    output logic                           range_fault,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [SAMPLE_BITS-1:0]         cfg_data
);

    map_sel_t                      map_sel_reg;
    logic signed [SAMPLE_BITS-1:0] range_min_reg;
    logic signed [SAMPLE_BITS-1:0] range_max_reg;

    logic en;

    // stage 1: input
    logic                          s1_vld_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    // stage 2: clamp
    logic                          s2_vld_reg, s2_fault_reg;
    map_sel_t                      s2_sel_reg;
    logic [DW-1:0]                 s2_d_reg, s2_w_reg;
    logic                          s2_fault_next;
    logic [DW-1:0]                 s2_d_next, s2_w_next;
    // stage 3: segment
    logic                          s3_vld_reg, s3_fault_reg;
    map_sel_t                      s3_sel_reg;
    logic [DW-1:0]                 s3_d_reg, s3_w_reg;
    seg_t                          s3_seg_reg, s3_seg_next;
    // stage 4: numerators
    logic                          s4_vld_reg, s4_fault_reg;
    logic [DW-1:0]                 s4_w_reg;
    logic signed [NW-1:0]          s4_num_reg [3];
    logic signed [NW-1:0]          s4_num_next [3];
    logic [2:0]                    s4_full_reg, s4_full_next;
    // stage 5: dividend and divisor
    logic                          s5_vld_reg, s5_fault_reg;
    logic [RW-1:0]                 s5_rem_reg [3];
    logic [RW-1:0]                 s5_rem_next [3];
    logic [YW-1:0]                 s5_y_reg, s5_y_next;
    // divider stages
    logic                          dv_vld_reg   [DIV_STAGES];
    logic                          dv_fault_reg [DIV_STAGES];
    logic [YW-1:0]                 dv_y_reg     [DIV_STAGES];
    logic [RW-1:0]                 dv_rem_reg   [DIV_STAGES][3];
    logic [CHANNEL_BITS-1:0]       dv_q_reg     [DIV_STAGES][3];
    logic [RW-1:0]                 dv_rem_next  [DIV_STAGES][3];
    logic [CHANNEL_BITS-1:0]       dv_q_next    [DIV_STAGES][3];

    assign out_valid = dv_vld_reg[DIV_STAGES-1];
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_sel_reg   <= MAP_JET;
            range_min_reg <= '0;
            range_max_reg <= SAMPLE_BITS'(1 << FRAC_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_SELECT: map_sel_reg   <= map_sel_t'(cfg_data[2:0]);
                REG_RANGE_MIN:  range_min_reg <= cfg_data;
                REG_RANGE_MAX:  range_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 2 logic: clamp ----------------
    always_comb
    begin
        logic signed [SW-1:0] v10, lo, hi, vc;
        logic signed [SW:0]   dd, ww;
        v10 = times10(s1_sample_reg);
        if (map_sel_reg == MAP_JET_FIXED)
        begin
            lo = FIXED_LO;
            hi = FIXED_HI;
        end
        else
        begin
            lo = times10(range_min_reg);
            hi = times10(range_max_reg);
        end
        s2_fault_next = (hi <= lo);
        vc = v10;
        if (vc < lo)
            vc = lo;
        if (vc > hi)
            vc = hi;
        dd = (SW+1)'(vc) - (SW+1)'(lo);
        ww = (SW+1)'(hi) - (SW+1)'(lo);
        s2_d_next = dd[DW-1:0];
        s2_w_next = ww[DW-1:0];
    end

    // ---------------- stage 3 logic: segment ----------------
    always_comb
    begin
        logic [CW-1:0] d, w;
        d = CW'(s2_d_reg);
        w = CW'(s2_w_reg);
        case (s2_sel_reg)
            MAP_HOT_TO_COLD:
                s3_seg_next = seg_t'(d * 4 >= w) + seg_t'(d * 4 >= w * 2)
                            + seg_t'(d * 4 >= w * 3);
            MAP_HOT:
                s3_seg_next = seg_t'(d * 8 >= w * 3) + seg_t'(d * 8 >= w * 6);
            MAP_COOL, MAP_WINTER, MAP_SUMMER:
                s3_seg_next = '0;
            default:
                s3_seg_next = seg_t'(d * 100 >= w * 11) + seg_t'(d * 100 >= w * 36)
                            + seg_t'(d * 100 >= w * 61) + seg_t'(d * 100 >= w * 86);
        endcase
    end

    // ---------------- stage 4 logic: numerators over 400 * width ----------------
    always_comb
    begin
        logic signed [NW-1:0] dn, wn;
        dn = signed'(NW'(s3_d_reg));
        wn = signed'(NW'(s3_w_reg));
        for (int c = 0; c < 3; c++)
            s4_num_next[c] = '0;
        s4_full_next = '0;
        case (s3_sel_reg)
            MAP_HOT_TO_COLD:
            begin
                case (s3_seg_reg)
                    3'd0:
                    begin
                        s4_num_next[1] = dn * 1600;
                        s4_full_next[2] = 1'b1;
                    end
                    3'd1:
                    begin
                        s4_full_next[1] = 1'b1;
                        s4_num_next[2] = wn * 800 - dn * 1600;
                    end
                    3'd2:
                    begin
                        s4_num_next[0] = dn * 1600 - wn * 800;
                        s4_full_next[1] = 1'b1;
                    end
                    default:
                    begin
                        s4_full_next[0] = 1'b1;
                        s4_num_next[1] = wn * 1600 - dn * 1600;
                    end
                endcase
            end
            MAP_COOL:
            begin
                s4_num_next[0] = dn * 400;
                s4_num_next[1] = wn * 400 - dn * 400;
                s4_full_next[2] = 1'b1;
            end
            MAP_WINTER:
            begin
                s4_num_next[1] = dn * 400;
                s4_num_next[2] = wn * 400 - dn * 200;
            end
            MAP_HOT:
            begin
                case (s3_seg_reg)
                    3'd0:
                        s4_num_next[0] = (dn + NW'(O2)) * 1600;
                    3'd1:
                    begin
                        s4_full_next[0] = 1'b1;
                        s4_num_next[1] = dn * 1600 - wn * 600;
                    end
                    default:
                    begin
                        s4_full_next[1:0] = 2'b11;
                        s4_num_next[2] = dn * 1600 - wn * 1200;
                    end
                endcase
            end
            MAP_SUMMER:
            begin
                s4_num_next[0] = dn * 440;
                s4_num_next[1] = dn * 400 + wn * 120;
                s4_num_next[2] = wn * 160;
            end
            default:
            begin
                case (s3_seg_reg)
                    3'd0:
                        s4_num_next[2] = (dn + NW'(O8)) * 1600;
                    3'd1:
                    begin
                        s4_num_next[1] = dn * 1600 - wn * 176;
                        s4_full_next[2] = 1'b1;
                    end
                    3'd2:
                    begin
                        s4_num_next[0] = dn * 1600 - wn * 576;
                        s4_full_next[1] = 1'b1;
                        s4_num_next[2] = wn * 976 - dn * 1600;
                    end
                    3'd3:
                    begin
                        s4_full_next[0] = 1'b1;
                        s4_num_next[1] = wn * 1376 - dn * 1600;
                    end
                    default:
                        s4_num_next[0] = wn * 1776 + NW'(1600 * O2) - dn * 1600;
                endcase
            end
        endcase
    end

    // ---------------- stage 5 logic: saturate, build dividend ----------------
    // level = floor((2*CMAX*num + den) / (2*den)); saturated channels get a
    // dividend of zero or CMAX times the divisor
    always_comb
    begin
        logic signed [NW-1:0] den;
        den = signed'(NW'(s4_w_reg)) * 400;
        s5_y_next = YW'(s4_w_reg) * YW'(800);
        for (int c = 0; c < 3; c++)
        begin
            if (s4_fault_reg)
                s5_rem_next[c] = '0;
            else if (s4_full_reg[c] || s4_num_reg[c] >= den)
                s5_rem_next[c] = RW'(s5_y_next) * RW'(CMAX);
            else if (s4_num_reg[c] <= 0)
                s5_rem_next[c] = '0;
            else
                s5_rem_next[c] = RW'(s4_num_reg[c]) * RW'(2 * CMAX) + RW'(den);
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    always_comb
    begin
        logic [RW-1:0]           rem_in, ysh;
        logic [CHANNEL_BITS-1:0] q_in;
        logic [YW-1:0]           y_in;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            y_in = (k == 0) ? s5_y_reg : dv_y_reg[k-1];
            ysh  = RW'(y_in) << (CHANNEL_BITS - 1 - k);
            for (int c = 0; c < 3; c++)
            begin
                rem_in = (k == 0) ? s5_rem_reg[c] : dv_rem_reg[k-1][c];
                q_in   = (k == 0) ? '0 : dv_q_reg[k-1][c];
                dv_q_next[k][c] = q_in;
                if (rem_in >= ysh)
                begin
                    dv_rem_next[k][c] = rem_in - ysh;
                    dv_q_next[k][c][CHANNEL_BITS-1-k] = 1'b1;
                end
                else
                    dv_rem_next[k][c] = rem_in;
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            dv_vld_reg[0] <= s5_vld_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sample_reg <= sample_value;

            s2_sel_reg   <= map_sel_reg;
            s2_fault_reg <= s2_fault_next;
            s2_d_reg     <= s2_d_next;
            s2_w_reg     <= s2_w_next;

            s3_sel_reg   <= s2_sel_reg;
            s3_fault_reg <= s2_fault_reg;
            s3_d_reg     <= s2_d_reg;
            s3_w_reg     <= s2_w_reg;
            s3_seg_reg   <= s3_seg_next;

            s4_fault_reg <= s3_fault_reg;
            s4_w_reg     <= s3_w_reg;
            s4_num_reg   <= s4_num_next;
            s4_full_reg  <= s4_full_next;

            s5_fault_reg <= s4_fault_reg;
            s5_rem_reg   <= s5_rem_next;
            s5_y_reg     <= s5_y_next;

            dv_fault_reg[0] <= s5_fault_reg;
            dv_y_reg[0]     <= s5_y_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dv_fault_reg[k] <= dv_fault_reg[k-1];
                dv_y_reg[k]     <= dv_y_reg[k-1];
            end
            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
        end
    end

    // a bad range yields black
    assign range_fault = dv_fault_reg[DIV_STAGES-1];
    assign red_level   = range_fault ? '0 : dv_q_reg[DIV_STAGES-1][0];
    assign green_level = range_fault ? '0 : dv_q_reg[DIV_STAGES-1][1];
    assign blue_level  = range_fault ? '0 : dv_q_reg[DIV_STAGES-1][2];

endmodule

/* sv/pcm_checker.sv */
// ----------------------------------------------------------------------------
// pcm_checker: port-level checks for the pseudocolor map
// Watches the top-level ports only; bound to every pseudocolor_map instance.
// ----------------------------------------------------------------------------
module pcm_checker import pcm_pkg::*; (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [CHANNEL_BITS-1:0]       red_level,
    input logic [CHANNEL_BITS-1:0]       green_level,
    input logic [CHANNEL_BITS-1:0]       blue_level,
    input logic                          range_fault
);

    // an empty output slot never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no item waiting at the output");

    // a stalled item stays on the port
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red_level) && $stable(green_level)
                                    && $stable(blue_level) && $stable(range_fault))
        else $error("output item changed while stalled");

    // a faulted item is black
    a_fault_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_fault |-> red_level == '0 && green_level == '0
                                     && blue_level == '0)
        else $error("range fault with nonzero color");

endmodule

bind pseudocolor_map pcm_checker u_pcm_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the pseudocolor map
// Drives samples through every map under several range settings and compares each color
// with an integer model of the piecewise-linear maps, in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
    import pcm_pkg::*;

    localparam logic [CHANNEL_BITS-1:0] LEVEL_MAX = CHANNEL_BITS'(CMAX);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic                    fault;
    } color_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          known;
        color_t                        color;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [CHANNEL_BITS-1:0]       red_level;
    logic [CHANNEL_BITS-1:0]       green_level;
    logic [CHANNEL_BITS-1:0]       blue_level;
    logic                          range_fault;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = REG_MAP_SELECT;
    logic [SAMPLE_BITS-1:0]        cfg_data = '0;

    logic [2:0]                    cur_map_bits;
    logic signed [SAMPLE_BITS-1:0] cur_min;
    logic signed [SAMPLE_BITS-1:0] cur_max;

    color_t   pending_colors[$];
    int       fail_count = 0;
    bit       long_hold = 1'b0;
    stim_row_t directed_rows[$];

    pseudocolor_map DUT (.*);

    always #6 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("pseudocolor_map regression: fail");
        $finish;
    end

    function automatic logic [CHANNEL_BITS-1:0] level_of(longint num, longint den);
        if (num <= 0)
            return '0;
        if (num >= den)
            return LEVEL_MAX;
        return CHANNEL_BITS'((2 * num * CMAX + den) / (2 * den));
    endfunction

    function automatic color_t map_color(logic signed [SAMPLE_BITS-1:0] s);
        color_t c;
        longint v, lo, hi, d, span;
        longint o8, o2;
        c = '0;
        o8 = 80 * (longint'(1) << FRAC_BITS);
        o2 = 20 * (longint'(1) << FRAC_BITS);
        v = 100 * longint'(s);
        if (cur_map_bits == 3'(MAP_JET_FIXED))
        begin
            lo = -10 * (longint'(1) << FRAC_BITS);
            hi = 30 * (longint'(1) << FRAC_BITS);
        end
        else
        begin
            lo = 100 * longint'(cur_min);
            hi = 100 * longint'(cur_max);
        end
        if (hi <= lo)
        begin
            c.fault = 1'b1;
            return c;
        end
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        d = v - lo;
        span = hi - lo;
        case (cur_map_bits)
            3'(MAP_HOT_TO_COLD):
                if (100 * d < 25 * span)
                begin
                    c.green = level_of(4 * d, span); c.blue = LEVEL_MAX;
                end
                else if (100 * d < 50 * span)
                begin
                    c.green = LEVEL_MAX; c.blue = level_of(2 * span - 4 * d, span);
                end
                else if (100 * d < 75 * span)
                begin
                    c.red = level_of(4 * d - 2 * span, span); c.green = LEVEL_MAX;
                end
                else
                begin
                    c.red = LEVEL_MAX; c.green = level_of(4 * span - 4 * d, span);
                end
            3'(MAP_COOL):
            begin
                c.red = level_of(d, span);
                c.green = level_of(span - d, span);
                c.blue = LEVEL_MAX;
            end
            3'(MAP_WINTER):
            begin
                c.green = level_of(d, span);
                c.blue = level_of(2 * span - d, 2 * span);
            end
            3'(MAP_HOT):
                if (64 * d < 24 * span)
                    c.red = level_of(4 * (d + o2), span);
                else if (64 * d < 48 * span)
                begin
                    c.red = LEVEL_MAX; c.green = level_of(64 * d - 24 * span, 16 * span);
                end
                else
                begin
                    c.red = LEVEL_MAX; c.green = LEVEL_MAX;
                    c.blue = level_of(64 * d - 48 * span, 16 * span);
                end
            3'(MAP_SUMMER):
            begin
                c.red = level_of(11 * d, 10 * span);
                c.green = level_of(10 * d + 3 * span, 10 * span);
                c.blue = level_of(2, 5);
            end
            default:
                if (100 * d < 11 * span)
                    c.blue = level_of(4 * (d + o8), span);
                else if (100 * d < 36 * span)
                begin
                    c.green = level_of(400 * d - 44 * span, 100 * span);
                    c.blue = LEVEL_MAX;
                end
                else if (100 * d < 61 * span)
                begin
                    c.red = level_of(400 * d - 144 * span, 100 * span);
                    c.green = LEVEL_MAX;
                    c.blue = level_of(244 * span - 400 * d, 100 * span);
                end
                else if (100 * d < 86 * span)
                begin
                    c.red = LEVEL_MAX;
                    c.green = level_of(344 * span - 400 * d, 100 * span);
                end
                else
                    c.red = level_of(444 * span + 400 * o2 - 400 * d, 100 * span);
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [SAMPLE_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAP_SELECT: cur_map_bits = value[2:0];
            REG_RANGE_MIN: cur_min = value;
            REG_RANGE_MAX: cur_max = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_maps(logic [2:0] m, logic [SAMPLE_BITS-1:0] lo_v,
                            logic [SAMPLE_BITS-1:0] hi_v);
        write_reg(REG_MAP_SELECT, SAMPLE_BITS'(m));
        write_reg(REG_RANGE_MIN, lo_v);
        write_reg(REG_RANGE_MAX, hi_v);
    endtask

    // send one item; 'known' rows are also compared against the typed color
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, int gap,
                               logic known = 1'b0, color_t typed = '0);
        color_t c;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            sample_value <= SAMPLE_BITS'($urandom);
            repeat (gap) @(negedge clk);
        end
        c = map_color(s);
        if (known && c !== typed)
        begin
            $error("typed color: expected %h, model gives %h", typed, c);
            fail_count++;
        end
        in_valid <= 1'b1;
        sample_value <= s;
        do @(posedge clk); while (!in_ready);
        pending_colors.push_back(c);
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        if (in_valid)
        begin
            in_valid <= 1'b0;
            sample_value <= SAMPLE_BITS'($urandom);
        end
        while (pending_colors.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    // sink side: draw a stall per item, or hold off for a long stretch
    initial
    begin
        int wait_cycles;
        color_t want;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (60) @(negedge clk);
                long_hold = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 4) == 0) wait_cycles = 0;
            if (wait_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_colors.size() == 0)
            begin
                $error("color arrived with none pending");
                fail_count++;
                continue;
            end
            want = pending_colors.pop_front();
            if (red_level !== want.red)
            begin
                $error("red_level: expected %0d, actual %0d", want.red, red_level);
                fail_count++;
            end
            if (green_level !== want.green)
            begin
                $error("green_level: expected %0d, actual %0d", want.green, green_level);
                fail_count++;
            end
            if (blue_level !== want.blue)
            begin
                $error("blue_level: expected %0d, actual %0d", want.blue, blue_level);
                fail_count++;
            end
            if (range_fault !== want.fault)
            begin
                $error("range_fault: expected %0d, actual %0d", want.fault, range_fault);
                fail_count++;
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int gap;
        logic [2:0] m;
        logic signed [SAMPLE_BITS-1:0] lo_v, hi_v;
        cur_map_bits = 3'(MAP_JET);
        cur_min = '0;
        cur_max = 16'sd4096;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // after reset: jet over 0..1.0
        directed_rows = '{
            '{16'sh8000, 1'b1, '{8'd0, 8'd0, 8'd255, 1'b0}},
            '{16'sd0,    1'b1, '{8'd0, 8'd0, 8'd255, 1'b0}},
            '{16'sh7fff, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b0}},
            '{16'sd4096, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b0}},
            '{16'sd450,  1'b0, '0},
            '{16'sd1500, 1'b0, '0},
            '{16'sd2048, 1'b0, '0},
            '{16'sd3000, 1'b0, '0},
            '{16'sd3600, 1'b0, '0},
            '{-16'sd1,   1'b0, '0}
        };
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_sample(row.sample, $urandom_range(0, 3), row.known, row.color);
        end
        drain();

        // every map once over the unit range, plus the unused selector
        for (int k = 0; k < 8; k++)
        begin
            set_maps(3'(k), 16'sd0, 16'sd4096);
            send_sample(16'sd0, 0);
            send_sample(16'sd1024, 1);
            send_sample(16'sd4096, 0);
            send_sample(16'sd2900, 2);
            drain();
        end

        // empty and inverted ranges fault, except on the fixed jet
        set_maps(3'(MAP_COOL), 16'sd100, 16'sd100);
        send_sample(16'sd100, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1});
        drain();
        set_maps(3'(MAP_HOT), 16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1});
        drain();
        set_maps(3'(MAP_JET_FIXED), 16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 0);
        drain();
        // widest range
        set_maps(3'(MAP_SUMMER), 16'sh8000, 16'sh7fff);
        send_sample(16'sh8000, 0);
        send_sample(16'sh7fff, 0);
        drain();

        // random phases; a few with a long sink hold-off and source back-to-back
        for (int ph = 0; ph < 14; ph++)
        begin
            m = 3'($urandom);
            case ($urandom_range(0, 5))
                0: begin lo_v = SAMPLE_BITS'($urandom); hi_v = SAMPLE_BITS'($urandom); end
                1: begin lo_v = 16'sh8000; hi_v = 16'sh7fff; end
                2: begin lo_v = SAMPLE_BITS'($urandom_range(0, 2000)) - 16'sd1000;
                         hi_v = lo_v + SAMPLE_BITS'($urandom_range(1, 40)); end
                default: begin lo_v = -SAMPLE_BITS'($urandom_range(0, 8192));
                               hi_v = SAMPLE_BITS'($urandom_range(1, 8192)); end
            endcase
            set_maps(m, lo_v, hi_v);
            if (ph % 5 == 2)
                long_hold = 1'b1;
            for (int n = 0; n < 50; n++)
            begin
                gap = (ph % 5 == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 2) == 0)
                    send_sample(SAMPLE_BITS'($urandom), gap);
                else if (hi_v > lo_v)
                    send_sample(lo_v + SAMPLE_BITS'($urandom_range(0,
                        int'(hi_v) - int'(lo_v))), gap);
                else
                    send_sample(lo_v + SAMPLE_BITS'($urandom_range(0, 16)) - 16'sd8, gap);
            end
            // source waits for every outstanding color before the next setting
            drain();
        end

        drain();
        if (fail_count == 0 && pending_colors.size() == 0)
            $display("pseudocolor_map regression: pass");
        else
            $display("pseudocolor_map regression: fail");
        $finish;
    end

endmodule
